// ===== rtl/rgb422_pkg.sv =====
// ============================================================================
// rgb422_pkg
// Constants and conversion functions for the RGB pair to YCbCr 4:2:2 block.
// ============================================================================
package rgb422_pkg;

  localparam int unsigned CompW   = 8;
  localparam int unsigned InDataW = 6 * CompW;
  localparam int unsigned OutDataW = 4 * CompW;

  // BT.601 full-range coefficients
  localparam longint LUMA_KR   = 299;
  localparam longint LUMA_KG   = 587;
  localparam longint LUMA_KB   = 114;
  localparam longint LUMA_DIV  = 1000;
  localparam longint CB_KR     = 16874;
  localparam longint CB_KG     = 33126;
  localparam longint CB_KB     = 50000;
  localparam longint CR_KR     = 50000;
  localparam longint CR_KG     = 41869;
  localparam longint CR_KB     = 8131;
  localparam longint CHROMA_OFFSET = 12800000;
  localparam longint CHROMA_DIV    = 100000;

  // Division by reciprocal: floor(x / d) == (x * M) >> S for every x in range.
  // Luma numerator < 2^18, chroma numerator < 2^25.
  localparam int unsigned LUMA_SHIFT   = 28;
  localparam int unsigned CHROMA_SHIFT = 42;
  localparam longint LUMA_RECIP   = ((64'sd1 <<< LUMA_SHIFT) + LUMA_DIV - 1) / LUMA_DIV;
  localparam longint CHROMA_RECIP =
    ((64'sd1 <<< CHROMA_SHIFT) + CHROMA_DIV - 1) / CHROMA_DIV;

  localparam int unsigned LumaAccW   = LUMA_SHIFT + CompW + 1;
  localparam int unsigned ChromaAccW = CHROMA_SHIFT + CompW + 2;

  typedef logic [LumaAccW-1:0]   luma_acc_t;
  typedef logic [ChromaAccW-1:0] chroma_acc_t;
  typedef logic [CompW-1:0]      comp_t;

  // Coefficients premultiplied by the reciprocal, so the divide folds into
  // one sum of constant products.
  localparam luma_acc_t   LUMA_R_M = LumaAccW'(LUMA_KR * LUMA_RECIP);
  localparam luma_acc_t   LUMA_G_M = LumaAccW'(LUMA_KG * LUMA_RECIP);
  localparam luma_acc_t   LUMA_B_M = LumaAccW'(LUMA_KB * LUMA_RECIP);
  localparam chroma_acc_t CB_R_M   = ChromaAccW'(CB_KR * CHROMA_RECIP);
  localparam chroma_acc_t CB_G_M   = ChromaAccW'(CB_KG * CHROMA_RECIP);
  localparam chroma_acc_t CB_B_M   = ChromaAccW'(CB_KB * CHROMA_RECIP);
  localparam chroma_acc_t CR_R_M   = ChromaAccW'(CR_KR * CHROMA_RECIP);
  localparam chroma_acc_t CR_G_M   = ChromaAccW'(CR_KG * CHROMA_RECIP);
  localparam chroma_acc_t CR_B_M   = ChromaAccW'(CR_KB * CHROMA_RECIP);
  localparam chroma_acc_t OFFSET_M = ChromaAccW'(CHROMA_OFFSET * CHROMA_RECIP);

  function automatic comp_t luma_of(comp_t r, comp_t g, comp_t b);
    luma_acc_t acc;
    acc = luma_acc_t'(r) * LUMA_R_M + luma_acc_t'(g) * LUMA_G_M
        + luma_acc_t'(b) * LUMA_B_M;
    return acc[LUMA_SHIFT +: CompW];
  endfunction

  // Wraps modulo 2^ChromaAccW; true result is non-negative and fits.
  function automatic comp_t cb_of(comp_t r, comp_t g, comp_t b);
    chroma_acc_t acc;
    acc = chroma_acc_t'(b) * CB_B_M + OFFSET_M
        - chroma_acc_t'(r) * CB_R_M - chroma_acc_t'(g) * CB_G_M;
    return acc[CHROMA_SHIFT +: CompW];
  endfunction

  function automatic comp_t cr_of(comp_t r, comp_t g, comp_t b);
    chroma_acc_t acc;
    acc = chroma_acc_t'(r) * CR_R_M + OFFSET_M
        - chroma_acc_t'(g) * CR_G_M - chroma_acc_t'(b) * CR_B_M;
    return acc[CHROMA_SHIFT +: CompW];
  endfunction

  function automatic comp_t avg_floor(comp_t a, comp_t b);
    logic [CompW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CompW:1];
  endfunction

endpackage

// ===== rtl/rgb_pair_to_ycbcr422.sv =====
// Pipeline: an accepted request passes through the input reg, then the result reg.
// Throughput: one pixel pair per clock while out_tready stays high; conversion is single-pass logic
//   between the input register and the result register.
// Backpressure stalls both registers; a new request is taken while a result
//   waits only if the input register is empty.
// Reset: both valid flags clear; data registers are not reset.
// ============================================================================
// rgb_pair_to_ycbcr422
// Converts two adjacent RGB888 pixels into one packed BT.601 YCbCr 4:2:2 word.
// ============================================================================
module rgb_pair_to_ycbcr422
  import rgb422_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // red_first, green_first, blue_first, red_second, green_second, blue_second
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // luma_first, chroma_blue, luma_second, chroma_red
  output logic [OutDataW-1:0] out_tdata
);

  logic                s1_vld_r, s1_vld_nxt;
  logic [InDataW-1:0]  s1_data_r;
  logic                out_vld_r, out_vld_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                out_adv;
  logic                in_acc;

  comp_t r1, g1, b1, r2, g2, b2;

  assign out_adv   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign r1 = s1_data_r[0*CompW +: CompW];
  assign g1 = s1_data_r[1*CompW +: CompW];
  assign b1 = s1_data_r[2*CompW +: CompW];
  assign r2 = s1_data_r[3*CompW +: CompW];
  assign g2 = s1_data_r[4*CompW +: CompW];
  assign b2 = s1_data_r[5*CompW +: CompW];

  always_comb begin
    out_data_nxt = {avg_floor(cr_of(r1, g1, b1), cr_of(r2, g2, b2)),
                    luma_of(r2, g2, b2),
                    avg_floor(cb_of(r1, g1, b1), cb_of(r2, g2, b2)),
                    luma_of(r1, g1, b1)};
  end

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    if (out_adv) begin
      out_vld_nxt = s1_vld_r;
    end
    if (in_tready) begin
      s1_vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
    end
    if (out_adv && s1_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // stalled input stage holds its pixel pair
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_adv |=> s1_vld_r && $stable(s1_data_r))
    else $error("input stage lost data under stall");

  a_acc_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted request not held in input stage");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_adv |=> out_vld_r)
    else $error("input stage moved without producing a result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_vld_r && !out_vld_r)
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/rgb_pair_to_ycbcr422_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rgb_pair_to_ycbcr422_tb
// Sends RGB pixel pairs through the converter with random gaps and back
// pressure on both streams. Each returned 4:2:2 word is checked field by
// field against an integer BT.601 computation of the same pair.
// ============================================================================
module rgb_pair_to_ycbcr422_tb;
  import rgb422_pkg::*;

  // in_tdata layout, highest bits first
  typedef struct packed {
    comp_t blue_second;
    comp_t green_second;
    comp_t red_second;
    comp_t blue_first;
    comp_t green_first;
    comp_t red_first;
  } pixel_pair_t;

  // out_tdata layout, highest bits first
  typedef struct packed {
    comp_t chroma_red;
    comp_t luma_second;
    comp_t chroma_blue;
    comp_t luma_first;
  } ycbcr_word_t;

  class ycbcr_scoreboard;
    ycbcr_word_t due_q[$];
    int unsigned mismatches;

    function int luma_level(int r, int g, int b);
      return (299 * r + 587 * g + 114 * b) / 1000;
    endfunction

    function int blue_diff(int r, int g, int b);
      return (50000 * b + 12800000 - 16874 * r - 33126 * g) / 100000;
    endfunction

    function int red_diff(int r, int g, int b);
      return (50000 * r + 12800000 - 41869 * g - 8131 * b) / 100000;
    endfunction

    function void note_request(pixel_pair_t p);
      ycbcr_word_t w;
      int cb_sum;
      int cr_sum;
      cb_sum = blue_diff(p.red_first, p.green_first, p.blue_first)
             + blue_diff(p.red_second, p.green_second, p.blue_second);
      cr_sum = red_diff(p.red_first, p.green_first, p.blue_first)
             + red_diff(p.red_second, p.green_second, p.blue_second);
      w.luma_first  = comp_t'(luma_level(p.red_first, p.green_first, p.blue_first));
      w.luma_second = comp_t'(luma_level(p.red_second, p.green_second, p.blue_second));
      w.chroma_blue = comp_t'(cb_sum >> 1);
      w.chroma_red  = comp_t'(cr_sum >> 1);
      due_q.push_back(w);
    endfunction

    function void compare_field(string name, comp_t want, comp_t got);
      if (want !== got) begin
        mismatches++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(ycbcr_word_t got);
      ycbcr_word_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = due_q.pop_front();
      compare_field("luma_first", want.luma_first, got.luma_first);
      compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
      compare_field("luma_second", want.luma_second, got.luma_second);
      compare_field("chroma_red", want.chroma_red, got.chroma_red);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;

  ycbcr_scoreboard sb;
  bit              calm;  // no idling on either side while set

  rgb_pair_to_ycbcr422 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic pixel_pair_t make_pair(comp_t r1, comp_t g1, comp_t b1,
                                            comp_t r2, comp_t g2, comp_t b2);
    pixel_pair_t p;
    p.red_first    = r1;
    p.green_first  = g1;
    p.blue_first   = b1;
    p.red_second   = r2;
    p.green_second = g2;
    p.blue_second  = b2;
    return p;
  endfunction

  function automatic comp_t pick_component(int unsigned style);
    comp_t edges[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    if (style == 1) begin
      return edges[$urandom_range(0, 3)];
    end
    return comp_t'($urandom_range(0, 255));
  endfunction

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    int unsigned style;
    comp_t       grey;
    style = $urandom_range(0, 9);
    if (style >= 8) begin
      // greys and near-greys: chroma sits near the midpoint
      grey = comp_t'($urandom_range(0, 255));
      p = make_pair(grey, grey, grey, grey ^ comp_t'($urandom_range(0, 3)),
                    grey, grey ^ comp_t'($urandom_range(0, 3)));
    end else begin
      style = (style >= 6) ? 1 : 0;
      p = make_pair(pick_component(style), pick_component(style), pick_component(style),
                    pick_component(style), pick_component(style), pick_component(style));
    end
    return p;
  endfunction

  task automatic send_pair(pixel_pair_t p);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    sb.note_request(p);
  endtask

  // result side: random stalls per request
  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  initial begin
    pixel_pair_t directed_q[$];
    sb = new();
    calm = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_q.push_back(make_pair(0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_pair(255, 255, 255, 255, 255, 255));
    directed_q.push_back(make_pair(255, 0, 0, 255, 0, 0));        // Cr at its top
    directed_q.push_back(make_pair(0, 255, 0, 0, 255, 0));
    directed_q.push_back(make_pair(0, 0, 255, 0, 0, 255));        // Cb at its top
    directed_q.push_back(make_pair(255, 255, 0, 255, 255, 0));    // Cb at its floor
    directed_q.push_back(make_pair(0, 255, 255, 0, 255, 255));    // Cr at its floor
    directed_q.push_back(make_pair(255, 0, 0, 0, 0, 255));
    directed_q.push_back(make_pair(0, 0, 255, 255, 0, 0));
    directed_q.push_back(make_pair(255, 255, 255, 0, 0, 0));
    directed_q.push_back(make_pair(0, 0, 0, 255, 255, 255));
    directed_q.push_back(make_pair(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55));
    directed_q.push_back(make_pair(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa));
    directed_q.push_back(make_pair(1, 1, 1, 254, 254, 254));
    directed_q.push_back(make_pair(8'h80, 8'h80, 8'h80, 8'h7f, 8'h7f, 8'h7f));
    directed_q.push_back(make_pair(255, 255, 0, 0, 0, 255));      // Cb sum spans both ends
    directed_q.push_back(make_pair(0, 255, 255, 255, 0, 0));      // Cr sum spans both ends
    directed_q.push_back(make_pair(1, 0, 0, 0, 1, 0));
    directed_q.push_back(make_pair(0, 0, 1, 0, 0, 0));
    foreach (directed_q[i]) send_pair(directed_q[i]);

    for (int n = 0; n < 1900; n++) begin
      if (n % 150 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      if (n == 950) begin
        // drain: let every outstanding request come back before going on
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_pair(random_pair());
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("rgb_pair_to_ycbcr422_tb: PASS");
    end else begin
      $display("rgb_pair_to_ycbcr422_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("rgb_pair_to_ycbcr422_tb: FAIL");
    $finish;
  end

endmodule
